>>> src/size_class_bitmap_slot_allocator_macros.svh
// Assertion macros used by the allocator top-level RTL.
`ifndef SIZE_CLASS_BITMAP_SLOT_ALLOCATOR_MACROS_SVH
`define SIZE_CLASS_BITMAP_SLOT_ALLOCATOR_MACROS_SVH
`ifndef ASSERT_OFF
// Check a property on every rising edge outside reset.
`define SCBA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check a property on every rising edge, reset included.
`define SCBA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SCBA_ASSERT(lbl, clk, rst_n, prop, msg)
`define SCBA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

>>> src/scba_pkg.sv
// Types, codes and class tables of the size-class bitmap slot allocator.
`default_nettype none
package scba_pkg;

    localparam int MAX_CLASSES = 6;
    localparam int CLASS_SHIFT = 17;
    localparam int MAP_W       = 8;
    localparam int STATUS_W    = 3;
    localparam int OFFSET_W    = 20;
    localparam int CLASS_W     = 3;
    localparam int BLOCKS_W    = 11;
    localparam int BYTES_W     = 18;
    localparam int SIZE_W      = 16;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 56;

    // Block size and its log2 for each class
    localparam logic [9:0] CLASS_SIZE [MAX_CLASSES] = '{10'd8, 10'd16, 10'd32,
                                                        10'd128, 10'd256, 10'd512};
    localparam logic [3:0] CLASS_LOG2 [MAX_CLASSES] = '{4'd3, 4'd4, 4'd5,
                                                        4'd7, 4'd8, 4'd9};

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 3'd0,
        STAT_OVERSIZE  = 3'd1,
        STAT_FULL      = 3'd2,
        STAT_NOT_ALLOC = 3'd3,
        STAT_BAD_ADDR  = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FCHK,
        ST_DONE
    } t_state;

endpackage
`default_nettype wire

>>> src/scba_bitmap_mem.sv
// Slot bitmap memory with registered read and per-entry valid flags.
`default_nettype none
module scba_bitmap_mem
    import scba_pkg::*;
#(
    parameter int ADDR_W = 8,
    parameter int DEPTH  = 192
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [MAP_W-1:0]  i_wr_data,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [MAP_W-1:0]  o_rd_data
);

    logic [MAP_W-1:0] r_mem [DEPTH];
    logic             r_vld [DEPTH];
    logic [MAP_W-1:0] r_rd_data;
    logic             r_rd_vld;

    // Write and read the bitmap array
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    // Track which entries hold written data; reset marks all as free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_vld[i] <= 1'b0;
            end
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            r_rd_vld <= r_vld[i_rd_addr];
        end
    end

    // Unwritten entries read as all slots free
    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule
`default_nettype wire

>>> src/size_class_bitmap_slot_allocator.sv
// Flow: allocate passes ST_SCAN, reading bitmap bytes in turn from the hint, then ST_DONE;
//   free passes ST_FCHK, then ST_DONE; oversize and bad-address requests go to ST_DONE at once.
// Throughput: a new request is taken only in ST_IDLE, after the result is loaded; the scan
//   reads one bitmap byte per cycle via the single read port (at most (SLOTS_PER_CLASS+7)/8 bytes).
// Reset: synchronous, active low; bitmaps clear at once through per-entry valid flags,
//   hints and live totals clear to zero, no clearing pass.
`default_nettype none
`include "size_class_bitmap_slot_allocator_macros.svh"
module size_class_bitmap_slot_allocator
    import scba_pkg::*;
#(
    parameter int SLOTS_PER_CLASS = 256,
    parameter int NUM_CLASSES     = 6
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // Request stream
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // tdata: req_size[15:0], free_offset[35:16], zero[39:36]
    input  wire logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // tuser: req_type[0]
    input  wire logic                   i_s_axis_tuser,
    // Result stream
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    // tdata: status[2:0], block_offset[22:3], size_class[25:23],
    //        live_blocks[36:26], live_bytes[54:37], zero[55]
    output logic      [OUT_TDATA_W-1:0] o_m_axis_tdata
);

    localparam int NBYTES = (SLOTS_PER_CLASS + 7) / 8;
    localparam int BW     = (NBYTES > 1) ? $clog2(NBYTES) : 1;
    localparam int CIW    = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int AW     = CIW + BW;
    localparam int DEPTH  = NUM_CLASSES << BW;
    localparam int SOFF_W = CLASS_SHIFT;

    // Control and payload registers
    t_state                r_state, n_state;
    logic [CLASS_W-1:0]    r_cls, n_cls;
    logic [BW-1:0]         r_byte, n_byte;
    logic [2:0]            r_bit, n_bit;
    t_status               r_res_status, n_res_status;
    logic [OFFSET_W-1:0]   r_res_off, n_res_off;
    logic [CLASS_W-1:0]    r_res_cls, n_res_cls;
    logic [BW-1:0]         r_hint [NUM_CLASSES];
    logic                  hint_we;
    logic [BLOCKS_W-1:0]   r_blocks, n_blocks;
    logic [BYTES_W-1:0]    r_bytes, n_bytes;
    logic                  r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    // Memory port signals
    logic                  mem_wr_en;
    logic [AW-1:0]         mem_wr_addr;
    logic [MAP_W-1:0]      mem_wr_data;
    logic [AW-1:0]         mem_rd_addr;
    logic [MAP_W-1:0]      mem_rd_data;

    // Decode signals
    logic                  in_xfer;
    logic                  out_free;
    logic [SIZE_W-1:0]     req_size;
    logic [OFFSET_W-1:0]   req_off;
    logic                  a_hit;
    logic [CLASS_W-1:0]    a_cls;
    logic [CLASS_W-1:0]    f_cls;
    logic                  f_cls_ok;
    logic [CLASS_W-1:0]    f_cls_safe;
    logic [SOFF_W-1:0]     f_slot;
    logic                  f_slot_ok;
    logic [BW-1:0]         f_byte;
    logic [MAP_W-1:0]      free_bits;
    logic                  found;
    logic [2:0]            found_k;
    logic                  last_byte;
    logic                  bit_set;

    scba_bitmap_mem #(
        .ADDR_W (AW),
        .DEPTH  (DEPTH)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign in_xfer         = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign req_size        = i_s_axis_tdata[SIZE_W-1:0];
    assign req_off         = i_s_axis_tdata[SIZE_W+OFFSET_W-1:SIZE_W];

    // Decode the request and examine the bitmap byte just read
    always_comb begin
        a_hit = 1'b0;
        a_cls = '0;
        for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
            if (req_size <= SIZE_W'(CLASS_SIZE[c])) begin
                a_hit = 1'b1;
                a_cls = CLASS_W'(c);
            end
        end

        f_cls      = req_off[OFFSET_W-1:CLASS_SHIFT];
        f_cls_ok   = (int'(f_cls) < NUM_CLASSES);
        f_cls_safe = f_cls_ok ? f_cls : '0;
        f_slot     = req_off[SOFF_W-1:0] >> CLASS_LOG2[f_cls_safe];
        f_slot_ok  = (f_slot < SOFF_W'(SLOTS_PER_CLASS));
        f_byte     = f_slot[BW+2:3];

        for (int k = 0; k < MAP_W; k++) begin
            free_bits[k] = !mem_rd_data[k] && ((int'(r_byte) * 8 + k) < SLOTS_PER_CLASS);
        end
        found   = |free_bits;
        found_k = '0;
        for (int k = MAP_W - 1; k >= 0; k--) begin
            if (free_bits[k]) begin
                found_k = 3'(k);
            end
        end
        last_byte = (r_byte == BW'(NBYTES - 1));
        bit_set   = mem_rd_data[r_bit];
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    if (!i_s_axis_tuser) begin
                        n_state = a_hit ? ST_SCAN : ST_DONE;
                    end else begin
                        n_state = (f_cls_ok && f_slot_ok) ? ST_FCHK : ST_DONE;
                    end
                end
            end
            ST_SCAN: begin
                if (found || last_byte) begin
                    n_state = ST_DONE;
                end
            end
            ST_FCHK: n_state = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Memory access, result and total updates
    always_comb begin
        n_cls        = r_cls;
        n_byte       = r_byte;
        n_bit        = r_bit;
        n_res_status = r_res_status;
        n_res_off    = r_res_off;
        n_res_cls    = r_res_cls;
        n_blocks     = r_blocks;
        n_bytes      = r_bytes;
        hint_we      = 1'b0;
        mem_wr_en    = 1'b0;
        mem_wr_addr  = {r_cls[CIW-1:0], r_byte};
        mem_wr_data  = mem_rd_data;
        mem_rd_addr  = {r_cls[CIW-1:0], r_byte + BW'(1)};
        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_res_off = '0;
                    if (!i_s_axis_tuser) begin
                        n_cls        = a_cls;
                        n_byte       = r_hint[a_cls];
                        mem_rd_addr  = {a_cls[CIW-1:0], r_hint[a_cls]};
                        n_res_status = STAT_OVERSIZE;
                        n_res_cls    = '0;
                    end else begin
                        n_cls        = f_cls_safe;
                        n_byte       = f_byte;
                        n_bit        = f_slot[2:0];
                        mem_rd_addr  = {f_cls_safe[CIW-1:0], f_byte};
                        n_res_status = STAT_BAD_ADDR;
                        n_res_cls    = f_cls_safe;
                    end
                end
            end
            ST_SCAN: begin
                n_res_cls = r_cls;
                n_res_off = '0;
                if (found) begin
                    mem_wr_en    = 1'b1;
                    mem_wr_data  = mem_rd_data | (MAP_W'(1) << found_k);
                    hint_we      = 1'b1;
                    n_blocks     = r_blocks + BLOCKS_W'(1);
                    n_bytes      = r_bytes + BYTES_W'(CLASS_SIZE[r_cls]);
                    n_res_status = STAT_OK;
                    n_res_off    = {r_cls, SOFF_W'({r_byte, found_k}) << CLASS_LOG2[r_cls]};
                end else if (last_byte) begin
                    n_res_status = STAT_FULL;
                end else begin
                    // Advance; the next byte is being read this cycle
                    n_byte = r_byte + BW'(1);
                end
            end
            ST_FCHK: begin
                n_res_cls = r_cls;
                n_res_off = '0;
                if (bit_set) begin
                    mem_wr_en    = 1'b1;
                    mem_wr_data  = mem_rd_data & ~(MAP_W'(1) << r_bit);
                    hint_we      = 1'b1;
                    n_blocks     = r_blocks - BLOCKS_W'(1);
                    n_bytes      = r_bytes - BYTES_W'(CLASS_SIZE[r_cls]);
                    n_res_status = STAT_OK;
                end else begin
                    n_res_status = STAT_NOT_ALLOC;
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers and totals
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_blocks    <= '0;
            r_bytes     <= '0;
            r_out_valid <= 1'b0;
            for (int c = 0; c < NUM_CLASSES; c++) begin
                r_hint[c] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_blocks <= n_blocks;
            r_bytes  <= n_bytes;
            if (hint_we) begin
                r_hint[r_cls[CIW-1:0]] <= r_byte;
            end
            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cls        <= n_cls;
        r_byte       <= n_byte;
        r_bit        <= n_bit;
        r_res_status <= n_res_status;
        r_res_off    <= n_res_off;
        r_res_cls    <= n_res_cls;
        if (r_state == ST_DONE && out_free) begin
            r_out_data <= {1'b0, r_bytes, r_blocks, r_res_cls, r_res_off, r_res_status};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    `SCBA_ASSERT(a_wr_in_check, i_clk, i_rst_n, mem_wr_en |-> (r_state == ST_SCAN || r_state == ST_FCHK), "bitmap written outside a check state")
    `SCBA_ASSERT(a_blocks_bound, i_clk, i_rst_n, r_blocks <= BLOCKS_W'(NUM_CLASSES * SLOTS_PER_CLASS), "live block count exceeds capacity")
    `SCBA_ASSERT(a_alloc_count, i_clk, i_rst_n, (r_state == ST_SCAN && found) |=> (r_blocks == $past(r_blocks) + BLOCKS_W'(1)), "allocate did not bump live count")
    `SCBA_ASSERT(a_free_count, i_clk, i_rst_n, (r_state == ST_FCHK && bit_set) |=> (r_blocks == $past(r_blocks) - BLOCKS_W'(1)), "free did not drop live count")
    `SCBA_ASSERT(a_done_loads, i_clk, i_rst_n, (r_state == ST_DONE && out_free) |=> (r_out_valid && r_state == ST_IDLE), "result not loaded on leaving done")

endmodule
`default_nettype wire
